[src/jse_pkg.sv]
`default_nettype none

package jse_pkg;

    // Longest escape run one input byte can cause (surrogate pair).
    localparam int unsigned RUN_MAX   = 12;
    localparam int unsigned RUN_CNT_W = $clog2(RUN_MAX + 1);
    localparam int unsigned PEND_MAX  = 3;
    localparam int unsigned ESC_LEN   = 6;
    localparam int unsigned FRAG_W    = $clog2(ESC_LEN + 1);

    typedef logic [7:0] t_byte;
    typedef t_byte [ESC_LEN-1:0] t_six;

    // UTF-8 sequence being collected between input bytes.
    typedef struct packed {
        t_byte [PEND_MAX-1:0] bytes;
        logic  [1:0]          count;
        logic  [1:0]          needed;
    } t_pend;

    // Escaped text for one input byte, entry 0 goes out first.
    typedef struct packed {
        t_byte [RUN_MAX-1:0]  bytes;
        logic  [RUN_CNT_W-1:0] len;
    } t_run;

    localparam t_byte CH_QUOTE  = 8'h22;
    localparam t_byte CH_BSLASH = 8'h5C;
    localparam t_byte CH_HASH   = 8'h23;
    localparam t_byte CH_LOW_U  = 8'h75;
    localparam t_byte CH_LOW_B  = 8'h62;
    localparam t_byte CH_LOW_F  = 8'h66;
    localparam t_byte CH_LOW_N  = 8'h6E;
    localparam t_byte CH_LOW_R  = 8'h72;
    localparam t_byte CH_LOW_T  = 8'h74;
    localparam t_byte CH_ZERO   = 8'h30;
    localparam t_byte CH_UP_A   = 8'h41;
    localparam t_byte CH_BS     = 8'h08;
    localparam t_byte CH_FF     = 8'h0C;
    localparam t_byte CH_LF     = 8'h0A;
    localparam t_byte CH_CR     = 8'h0D;
    localparam t_byte CH_TAB    = 8'h09;
    localparam t_byte CH_SPACE  = 8'h20;
    localparam t_byte CH_DEL    = 8'h7F;

    localparam t_byte LEAD3_MIN    = 8'hE0;
    localparam t_byte LEAD4_MIN    = 8'hF0;
    localparam t_byte LEAD_BAD_MIN = 8'hF5;

    localparam logic [22:0] CP_MAX  = 23'h10FFFF;
    localparam logic [22:0] CP_SUPP = 23'h010000;
    localparam logic [15:0] SURR_HI = 16'hD800;
    localparam logic [15:0] SURR_LO = 16'hDC00;

endpackage

`default_nettype wire

[src/jse_encode.sv]
`default_nettype none

module jse_encode import jse_pkg::*; (
    input  t_byte i_byte,
    input  logic  i_end,
    input  logic  i_raw,
    input  t_pend i_pend,
    output t_run  o_run,
    output t_pend o_pend
);

    function automatic t_byte hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return CH_ZERO + {4'h0, nib};
        return CH_UP_A - 8'd10 + {4'h0, nib};
    endfunction

    // \uXXXX, backslash first
    function automatic t_six u16_esc(input logic [15:0] v);
        t_six s;
        s[0] = CH_BSLASH;
        s[1] = CH_LOW_U;
        s[2] = hex_char(v[15:12]);
        s[3] = hex_char(v[11:8]);
        s[4] = hex_char(v[7:4]);
        s[5] = hex_char(v[3:0]);
        return s;
    endfunction

    t_six              fr_bytes;
    logic [FRAG_W-1:0] fr_len;
    logic              fr_pend;
    logic [1:0]        fr_need;

    // Escape of a byte taken on its own, with no sequence pending.
    always_comb begin
        fr_bytes = '0;
        fr_len   = '0;
        fr_pend  = 1'b0;
        fr_need  = 2'd0;
        unique case (i_byte)
            CH_QUOTE: begin
                fr_bytes[0] = CH_BSLASH; fr_bytes[1] = CH_QUOTE; fr_len = FRAG_W'(2);
            end
            CH_BSLASH: begin
                fr_bytes[0] = CH_BSLASH; fr_bytes[1] = CH_BSLASH; fr_len = FRAG_W'(2);
            end
            CH_BS: begin
                fr_bytes[0] = CH_BSLASH; fr_bytes[1] = CH_LOW_B; fr_len = FRAG_W'(2);
            end
            CH_FF: begin
                fr_bytes[0] = CH_BSLASH; fr_bytes[1] = CH_LOW_F; fr_len = FRAG_W'(2);
            end
            CH_LF: begin
                fr_bytes[0] = CH_BSLASH; fr_bytes[1] = CH_LOW_N; fr_len = FRAG_W'(2);
            end
            CH_CR: begin
                fr_bytes[0] = CH_BSLASH; fr_bytes[1] = CH_LOW_R; fr_len = FRAG_W'(2);
            end
            CH_TAB: begin
                fr_bytes[0] = CH_BSLASH; fr_bytes[1] = CH_LOW_T; fr_len = FRAG_W'(2);
            end
            default: begin
                if (i_byte < CH_SPACE || i_byte == CH_DEL) begin
                    fr_bytes = u16_esc({8'h00, i_byte});
                    fr_len   = FRAG_W'(ESC_LEN);
                end else if (!i_raw && i_byte[7:6] == 2'b11) begin
                    // Bad lead, or a lead cut off by the end of the string
                    if (i_byte >= LEAD_BAD_MIN || i_end) begin
                        fr_bytes[0] = CH_HASH;
                        fr_bytes[1] = hex_char(i_byte[7:4]);
                        fr_bytes[2] = hex_char(i_byte[3:0]);
                        fr_len      = FRAG_W'(3);
                    end else begin
                        fr_pend = 1'b1;
                        fr_need = (i_byte < LEAD3_MIN) ? 2'd1 :
                                  ((i_byte < LEAD4_MIN) ? 2'd2 : 2'd3);
                    end
                end else begin
                    fr_bytes[0] = i_byte;
                    fr_len      = FRAG_W'(1);
                end
            end
        endcase
    end

    logic        pending;
    logic        is_cont;
    logic        complete;
    logic        emit_cp;
    logic        buffer;
    logic        flush;
    logic        use_fresh;
    t_byte       lead;
    logic [4:0]  lead_m;
    logic [22:0] cp;
    logic [22:0] cp_off;

    always_comb begin
        pending = i_pend.count != 2'd0;
        is_cont = i_byte[7:6] == 2'b10;
        lead    = i_pend.bytes[0];
        if (lead < LEAD3_MIN) begin
            lead_m = lead[4:0];
        end else if (lead < LEAD4_MIN) begin
            lead_m = {1'b0, lead[3:0]};
        end else begin
            lead_m = {2'b00, lead[2:0]};
        end
        unique case (i_pend.count)
            2'd1:    cp = {12'd0, lead_m, i_byte[5:0]};
            2'd2:    cp = {6'd0, lead_m, i_pend.bytes[1][5:0], i_byte[5:0]};
            2'd3:    cp = {lead_m, i_pend.bytes[1][5:0], i_pend.bytes[2][5:0], i_byte[5:0]};
            default: cp = '0;
        endcase
        cp_off    = cp - CP_SUPP;
        complete  = pending && is_cont && i_pend.needed <= 2'd1;
        emit_cp   = complete && cp <= CP_MAX;
        buffer    = pending && is_cont && !complete && i_pend.count < 2'd3;
        flush     = pending && !emit_cp && !(buffer && !i_end);
        use_fresh = !pending || !is_cont;
    end

    t_byte [RUN_MAX-1:0]  pre;
    t_byte [RUN_MAX-1:0]  suf;
    logic [RUN_CNT_W-1:0] plen;
    logic [RUN_CNT_W-1:0] slen;

    // Run = flushed prefix (#XX and buffered continuations) + suffix.
    always_comb begin
        pre    = '0;
        pre[0] = CH_HASH;
        pre[1] = hex_char(lead[7:4]);
        pre[2] = hex_char(lead[3:0]);
        pre[3] = i_pend.bytes[1];
        pre[4] = i_pend.bytes[2];
        plen   = flush ? RUN_CNT_W'(i_pend.count) + RUN_CNT_W'(2) : '0;

        suf  = '0;
        slen = '0;
        if (emit_cp) begin
            if (cp < CP_SUPP) begin
                suf[ESC_LEN-1:0] = u16_esc(cp[15:0]);
                slen             = RUN_CNT_W'(ESC_LEN);
            end else begin
                suf[ESC_LEN-1:0]       = u16_esc(SURR_HI | {6'd0, cp_off[19:10]});
                suf[RUN_MAX-1:ESC_LEN] = u16_esc(SURR_LO | {6'd0, cp_off[9:0]});
                slen                   = RUN_CNT_W'(RUN_MAX);
            end
        end else if (use_fresh) begin
            suf[ESC_LEN-1:0] = fr_bytes;
            slen             = RUN_CNT_W'(fr_len);
        end else if (flush) begin
            // Continuation that closes a broken or cut-off sequence passes as is
            suf[0] = i_byte;
            slen   = RUN_CNT_W'(1);
        end

        o_run.len = plen + slen;
        for (int i = 0; i < RUN_MAX; i++) begin
            if (RUN_CNT_W'(i) < plen) begin
                o_run.bytes[i] = pre[i];
            end else begin
                o_run.bytes[i] = suf[RUN_CNT_W'(i) - plen];
            end
        end
    end

    always_comb begin
        o_pend        = i_pend;
        o_pend.count  = 2'd0;
        o_pend.needed = 2'd0;
        if (buffer && !i_end) begin
            o_pend.bytes[i_pend.count] = i_byte;
            o_pend.count               = i_pend.count + 2'd1;
            o_pend.needed              = i_pend.needed - 2'd1;
        end else if (use_fresh && fr_pend) begin
            o_pend.bytes[0] = i_byte;
            o_pend.count    = 2'd1;
            o_pend.needed   = fr_need;
        end
    end

endmodule

`default_nettype wire

[src/json_string_escaper_top.sv]
`default_nettype none

// JSON string escaper. Feed the bytes of a string, one word per byte, with
// i_string_end on the last one; the escaped text comes out one byte per word.
// A byte that escapes to N bytes (N up to 12, surrogate pair) gives N output
// bytes; one that only joins a pending UTF-8 sequence gives none. Plain text
// flows at one byte per cycle while i_out_stall is low. The only limit is the
// output port, which moves one byte a cycle unless stalled: the next input
// word is encoded while the last byte of the current run goes out. An accepted
// word is held in an input register, its run in an output register. o_run_last
// marks the last byte of each input word's run, o_string_done the last byte of
// the string. Write i_cfg_wdata (raw UTF-8 pass-through) only while idle.
module json_string_escaper_top import jse_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,

    input  logic  i_cfg_we,
    input  logic  i_cfg_wdata,

    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_byte i_in_byte,
    input  logic  i_string_end,

    output logic  o_out_valid,
    input  logic  i_out_stall,
    output t_byte o_out_byte,
    output logic  o_run_last,
    output logic  o_string_done
);

    logic                 r_raw;
    logic                 r_in_valid;
    t_byte                r_in_byte;
    logic                 r_in_end;
    t_pend                r_pend;
    t_byte [RUN_MAX-1:0]  r_run_bytes;
    logic [RUN_CNT_W-1:0] r_run_cnt;
    logic                 r_run_end;

    logic                 n_in_valid;
    t_byte [RUN_MAX-1:0]  n_run_bytes;
    logic [RUN_CNT_W-1:0] n_run_cnt;

    logic  process;
    logic  accept_in;
    logic  out_take;
    t_run  enc_run;
    t_pend enc_pend;

    jse_encode u_encode (
        .i_byte (r_in_byte),
        .i_end  (r_in_end),
        .i_raw  (r_raw),
        .i_pend (r_pend),
        .o_run  (enc_run),
        .o_pend (enc_pend)
    );

    assign o_out_valid   = r_run_cnt != '0;
    assign o_out_byte    = r_run_bytes[0];
    assign o_run_last    = r_run_cnt == RUN_CNT_W'(1);
    assign o_string_done = o_run_last && r_run_end;

    assign out_take  = o_out_valid && !i_out_stall;
    // Load a new run once the current one is gone or leaves this cycle
    assign process   = r_in_valid && (r_run_cnt == '0 || (o_run_last && !i_out_stall));
    assign o_in_stall = r_in_valid && !process;
    assign accept_in = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept_in) begin
            n_in_valid = 1'b1;
        end else if (process) begin
            n_in_valid = 1'b0;
        end

        n_run_bytes = r_run_bytes;
        n_run_cnt   = r_run_cnt;
        if (process) begin
            n_run_bytes = enc_run.bytes;
            n_run_cnt   = enc_run.len;
        end else if (out_take) begin
            // advance to the next byte of the run
            n_run_bytes = {8'h00, r_run_bytes[RUN_MAX-1:1]};
            n_run_cnt   = r_run_cnt - RUN_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw         <= 1'b0;
            r_in_valid    <= 1'b0;
            r_run_cnt     <= '0;
            r_pend.count  <= 2'd0;
            r_pend.needed <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_raw <= i_cfg_wdata;
            end
            r_in_valid <= n_in_valid;
            r_run_cnt  <= n_run_cnt;
            if (process) begin
                r_pend.bytes  <= enc_pend.bytes;
                r_pend.count  <= enc_pend.count;
                r_pend.needed <= enc_pend.needed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in_byte <= i_in_byte;
            r_in_end  <= i_string_end;
        end
        if (process) begin
            r_run_end    <= r_in_end;
        end
        r_run_bytes <= n_run_bytes;
    end

`ifndef SYNTHESIS
    a_pend_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend.count != 2'd0) |->
            (r_pend.needed != 2'd0 &&
             ({1'b0, r_pend.count} + {1'b0, r_pend.needed}) <= 3'd4))
        else $error("pending sequence with inconsistent needed count");

    a_idle_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend.count == 2'd0) |-> (r_pend.needed == 2'd0))
        else $error("needed count left over with no sequence pending");

    a_run_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && enc_run.len != '0) |=>
            (o_out_valid && r_run_cnt == $past(enc_run.len)))
        else $error("encoded run not presented on the output");
`endif

endmodule

`default_nettype wire

[dv/testbench.sv]
module testbench;
    import jse_pkg::*;

    localparam logic  MODE_ESCAPE = 1'b0;
    localparam logic  MODE_RAW    = 1'b1;
    localparam t_byte LEAD2_MIN   = 8'hC0;
    localparam int    MAX_REPORTS = 10;
    localparam int    DRAIN_CYCLES = 20;

    typedef struct packed {
        t_byte text;
        logic  run_last;
        logic  str_done;
    } t_esc_out;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_cfg_we = 1'b0;
    logic  i_cfg_wdata = 1'b0;
    logic  i_in_valid = 1'b0;
    t_byte i_in_byte = '0;
    logic  i_string_end = 1'b0;
    logic  i_out_stall = 1'b0;
    logic  o_in_stall;
    logic  o_out_valid;
    t_byte o_out_byte;
    logic  o_run_last;
    logic  o_string_done;

    json_string_escaper_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_byte     (i_in_byte),
        .i_string_end  (i_string_end),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_string_done (o_string_done)
    );

    always #1 i_clk = ~i_clk;

    // Escaper model state
    logic        raw_mode = MODE_ESCAPE;
    t_byte       pend_bytes [PEND_MAX];
    logic [1:0]  pend_count = '0;
    logic [1:0]  pend_needed = '0;
    t_byte       esc_run_q [$];
    t_esc_out    esc_expected_q [$];

    // Run bookkeeping
    int  mismatches = 0;
    int  words_sent = 0;
    int  strings_sent = 0;
    int  bytes_checked = 0;
    int  mode_writes = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    int  rx_hold_req = 0;

    function automatic t_byte hex_digit(logic [3:0] n);
        return (n < 4'd10) ? t_byte'(CH_ZERO + {4'h0, n})
                           : t_byte'(CH_UP_A + {4'h0, n} - 8'd10);
    endfunction

    function automatic void emit(t_byte b);
        esc_run_q.push_back(b);
    endfunction

    function automatic void emit_hex(t_byte b);
        emit(hex_digit(b[7:4]));
        emit(hex_digit(b[3:0]));
    endfunction

    function automatic void emit_u16(logic [15:0] v);
        emit(CH_BSLASH);
        emit(CH_LOW_U);
        emit_hex(v[15:8]);
        emit_hex(v[7:0]);
    endfunction

    function automatic void emit_codepoint(int unsigned cp);
        logic [19:0] d;
        if (cp < CP_SUPP) begin
            emit_u16(cp[15:0]);
        end else begin
            d = 20'(cp - CP_SUPP);
            emit_u16(SURR_HI + 16'(d[19:10]));
            emit_u16(SURR_LO + 16'(d[9:0]));
        end
    endfunction

    function automatic void escape_fresh(t_byte b);
        case (b)
            CH_QUOTE: begin
                emit(CH_BSLASH); emit(CH_QUOTE);
            end
            CH_BSLASH: begin
                emit(CH_BSLASH); emit(CH_BSLASH);
            end
            CH_BS: begin
                emit(CH_BSLASH); emit(CH_LOW_B);
            end
            CH_FF: begin
                emit(CH_BSLASH); emit(CH_LOW_F);
            end
            CH_LF: begin
                emit(CH_BSLASH); emit(CH_LOW_N);
            end
            CH_CR: begin
                emit(CH_BSLASH); emit(CH_LOW_R);
            end
            CH_TAB: begin
                emit(CH_BSLASH); emit(CH_LOW_T);
            end
            default: begin
                if (b < CH_SPACE || b == CH_DEL) begin
                    emit_codepoint(int'(b));
                end else if (raw_mode == MODE_ESCAPE && b >= LEAD2_MIN) begin
                    if (b >= LEAD_BAD_MIN) begin
                        emit(CH_HASH);
                        emit_hex(b);
                    end else begin
                        pend_bytes[0] = b;
                        pend_count = 2'd1;
                        pend_needed = (b < LEAD3_MIN) ? 2'd1 : ((b < LEAD4_MIN) ? 2'd2 : 2'd3);
                    end
                end else begin
                    emit(b);
                end
            end
        endcase
    endfunction

    // Lead goes out as #XX, the buffered continuation bytes are re-escaped.
    function automatic void flush_broken();
        int n;
        n = int'(pend_count);
        pend_count = '0;
        pend_needed = '0;
        if (n != 0) begin
            emit(CH_HASH);
            emit_hex(pend_bytes[0]);
            for (int k = 1; k < n; k++) escape_fresh(pend_bytes[k]);
        end
    endfunction

    function automatic void predict_escape(t_byte b, logic str_end);
        int unsigned cp;
        t_byte       lead;
        int          n;
        t_esc_out    item;
        esc_run_q.delete();
        if (pend_count != 2'd0) begin
            if (b[7:6] == 2'b10) begin
                if (pend_needed <= 2'd1) begin
                    lead = pend_bytes[0];
                    if (lead < LEAD3_MIN) cp = 32'(lead & 8'h1F);
                    else if (lead < LEAD4_MIN) cp = 32'(lead & 8'h0F);
                    else cp = 32'(lead & 8'h07);
                    for (int i = 1; i < int'(pend_count); i++)
                        cp = (cp << 6) | 32'(pend_bytes[i] & 8'h3F);
                    cp = (cp << 6) | 32'(b & 8'h3F);
                    if (cp > CP_MAX) begin
                        flush_broken();
                        escape_fresh(b);
                    end else begin
                        pend_count = '0;
                        pend_needed = '0;
                        emit_codepoint(cp);
                    end
                end else if (pend_count < 2'd3) begin
                    pend_bytes[pend_count] = b;
                    pend_count = pend_count + 2'd1;
                    pend_needed = pend_needed - 2'd1;
                end else begin
                    flush_broken();
                    escape_fresh(b);
                end
            end else begin
                flush_broken();
                escape_fresh(b);
            end
        end else begin
            escape_fresh(b);
        end
        if (str_end && pend_count != 2'd0) flush_broken();
        n = (esc_run_q.size() > int'(RUN_MAX)) ? int'(RUN_MAX) : esc_run_q.size();
        for (int k = 0; k < n; k++) begin
            item.text = esc_run_q[k];
            item.run_last = (k == n - 1);
            item.str_done = (k == n - 1) && str_end;
            esc_expected_q.push_back(item);
        end
    endfunction

    function automatic bit pick_gap_short();
        return $urandom_range(0, 99) < 92;
    endfunction

    // Send one word; keep valid high when the next word follows at once.
    task automatic send_word(t_byte b, logic str_end);
        int gap;
        i_in_valid <= 1'b1;
        i_in_byte <= b;
        i_string_end <= str_end;
        do @(posedge i_clk); while (o_in_stall);
        predict_escape(b, str_end);
        words_sent++;
        if (str_end) strings_sent++;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 99) >= 60)
            gap = pick_gap_short() ? $urandom_range(1, 3) : $urandom_range(6, 30);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Send up to four bytes packed into seq, first byte in the highest used lane.
    task automatic send_seq(int n, logic [31:0] seq, logic end_last);
        for (int i = 0; i < n; i++)
            send_word(seq[8*(n-1-i) +: 8], end_last && (i == n - 1));
    endtask

    task automatic wait_idle();
        while (esc_expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(logic v);
        i_in_valid <= 1'b0;
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        raw_mode = v;
        mode_writes++;
    endtask

    task automatic note_mismatch(t_esc_out want, t_esc_out got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected byte %h last %b done %b, got byte %h last %b done %b",
                     want.text, want.run_last, want.str_done,
                     got.text, got.run_last, got.str_done);
    endtask

    task automatic check_result();
        t_esc_out got;
        t_esc_out want;
        got = '{o_out_byte, o_run_last, o_string_done};
        bytes_checked++;
        if (esc_expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("unexpected output byte %h last %b done %b",
                         got.text, got.run_last, got.str_done);
        end else begin
            want = esc_expected_q.pop_front();
            if (got.text !== want.text || got.run_last !== want.run_last ||
                got.str_done !== want.str_done)
                note_mismatch(want, got);
        end
    endtask

    // Output side: check accepted words, then pick the stall for the next cycle.
    int rx_stall_left = 0;
    int rx_hold_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_result();
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_stall <= 1'b1;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_out_stall <= 1'b1;
        end else if (rx_idle_on && $urandom_range(0, 99) >= 65) begin
            rx_stall_left = pick_gap_short() ? $urandom_range(0, 2) : $urandom_range(8, 40);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic test_plain_escapes();
        write_mode(MODE_ESCAPE);
        send_word(8'h00, 1'b0);
        send_word(8'h1F, 1'b0);
        send_word(CH_DEL, 1'b0);
        send_word(CH_QUOTE, 1'b0);
        send_word(CH_BSLASH, 1'b0);
        send_word(CH_BS, 1'b0);
        send_word(CH_FF, 1'b0);
        send_word(CH_LF, 1'b0);
        send_word(CH_CR, 1'b0);
        send_word(CH_TAB, 1'b0);
        send_word(8'h80, 1'b0);      // lone continuation
        send_word(8'hFF, 1'b1);      // invalid lead
    endtask

    task automatic test_utf8_sequences();
        send_seq(2, 32'h0000C3A9, 1'b0);
        send_seq(4, 32'hF09F9880, 1'b0);     // surrogate pair
        send_seq(4, 32'hF4908080, 1'b0);     // above the last code point
        send_seq(2, 32'h0000E241, 1'b0);     // broken by plain byte
        send_seq(2, 32'h0000C080, 1'b0);     // overlong
        send_seq(2, 32'h0000E282, 1'b1);     // string ends mid-sequence
    endtask

    task automatic test_raw_mode();
        write_mode(MODE_RAW);
        send_seq(2, 32'h0000C3A9, 1'b0);
        send_word(8'hFF, 1'b1);
        // switch modes with a sequence half collected
        write_mode(MODE_ESCAPE);
        send_word(8'hE2, 1'b0);
        write_mode(MODE_RAW);
        send_seq(2, 32'h000082AC, 1'b1);
    endtask

    task automatic send_random_byte(t_byte b);
        send_word(b, $urandom_range(0, 9) == 0);
    endtask

    task automatic test_random_text(logic mode, int count);
        int    start;
        int    kind;
        int    conts;
        t_byte lead;
        write_mode(mode);
        start = words_sent;
        while (words_sent - start < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                conts = $urandom_range(1, 3);
                case (conts)
                    1: lead = ($urandom_range(0, 9) == 0) ? t_byte'($urandom_range(8'hC0, 8'hC1))
                                                          : t_byte'($urandom_range(8'hC2, 8'hDF));
                    2: lead = t_byte'($urandom_range(8'hE0, 8'hEF));
                    default: lead = t_byte'($urandom_range(8'hF0, 8'hF4));
                endcase
                send_random_byte(lead);
                repeat (conts) send_random_byte(t_byte'($urandom_range(8'h80, 8'hBF)));
            end else if (kind < 75) begin
                send_random_byte(t_byte'($urandom_range(8'h00, 8'h7F)));
            end else if (kind < 90) begin
                send_random_byte(t_byte'($urandom_range(8'h00, 8'hFF)));
            end else begin
                // sequence cut short by a plain byte
                send_random_byte(t_byte'($urandom_range(8'hE0, 8'hF4)));
                repeat ($urandom_range(0, 1))
                    send_random_byte(t_byte'($urandom_range(8'h80, 8'hBF)));
                send_random_byte(t_byte'($urandom_range(8'h00, 8'h7F)));
            end
        end
    endtask

    task automatic test_backpressure(int count);
        write_mode(MODE_ESCAPE);
        tx_idle_on = 1'b0;
        rx_hold_req = 300;
        for (int i = 0; i < count; i++)
            send_word(t_byte'($urandom_range(8'h00, 8'h1F)), i == count - 1);
        tx_idle_on = 1'b1;
    endtask

    task automatic test_full_rate(int count);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_text(MODE_ESCAPE, count);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_plain_escapes();
        test_utf8_sequences();
        test_raw_mode();
        test_random_text(MODE_ESCAPE, 120);
        test_random_text(MODE_RAW, 80);
        test_backpressure(40);
        test_full_rate(60);
        test_random_text(MODE_ESCAPE, 80);
        i_in_valid <= 1'b0;
        while (esc_expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d input words in %0d strings, %0d mode writes, both modes",
                 words_sent, strings_sent, mode_writes);
        $display("checked %0d escaped bytes, %0d mismatches", bytes_checked, mismatches);
        if (mismatches == 0 && esc_expected_q.size() == 0) begin
            $display("json_string_escaper_top test passed");
        end else begin
            $display("json_string_escaper_top test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d bytes still expected", esc_expected_q.size());
        $display("json_string_escaper_top test failed");
        $finish;
    end

endmodule

[sim.f]
src/jse_pkg.sv
src/jse_encode.sv
src/json_string_escaper_top.sv
dv/testbench.sv
